// File: rtl/dqs_pkg.sv
// Shared request and status codes and field widths for the deque with search.
`timescale 1ns / 1ps
`default_nettype none
package dqs_pkg;

  localparam int REQ_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  typedef logic [REQ_W-1:0]    req_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [VALUE_W-1:0]  word_t;

  localparam req_t REQ_PUSH_FRONT = 3'd0;
  localparam req_t REQ_PUSH_BACK  = 3'd1;
  localparam req_t REQ_POP_FRONT  = 3'd2;
  localparam req_t REQ_POP_BACK   = 3'd3;
  localparam req_t REQ_SEARCH     = 3'd4;

  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_EMPTY = 2'd1;
  localparam status_t STATUS_FULL  = 2'd2;

endpackage
`default_nettype wire

// File: rtl/dqs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module dqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/deque_with_search.sv
// Top level of the bounded double-ended queue with value search.
`timescale 1ns / 1ps
`default_nettype none
// A bounded double-ended queue of 32-bit values held as a ring buffer of
// DEPTH words in one RAM. A request is taken on a clock edge with start high
// and busy low; its result appears on status, found and occupancy, marked by
// done high for a single cycle, and must be taken then since nothing holds it.
// Push, pop, unused codes and a search of an empty queue finish without a scan:
// the result beat shows up the cycle after the request and busy stays low, so
// a new request can follow every cycle. A search of a queue holding n entries
// reads the RAM one entry per cycle through its single read port: busy stays
// high through the scan and wait states, and done rises as busy falls. The
// entry store has no reset and no clearing pass; only entries written by a
// push are ever read. A push on a full queue is dropped with status full, a
// pop on an empty queue only reports status empty; found is zero outside a
// search. Occupancy reports the low five bits of the entry count.
module deque_with_search
  import dqs_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [REQ_W-1:0]          req_type,
  input  wire logic signed [VALUE_W-1:0] value,
  output logic                           done,
  output logic [STATUS_W-1:0]            status,
  output logic                           found,
  output logic [OCC_W-1:0]               occupancy
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  logic [1:0]    state;
  logic [AW-1:0] head;
  logic [AW-1:0] head_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [AW-1:0] idx;
  word_t         key;
  logic          hit;
  logic          pend;

  logic          accept;
  logic          full;
  logic          empty;
  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  word_t         rdata;
  logic          match;
  logic          last_issue;
  logic [AW-1:0] head_m1;
  logic [AW-1:0] head_p1;
  logic [AW-1:0] tail;
  status_t       res_status;

  // Wrap head plus an offset below DEPTH back into the ring.
  function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (AW + 1)'(DEPTH)) begin
      sum = sum - (AW + 1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign full   = (count == CW'(DEPTH));
  assign empty  = (count == '0);

  assign head_m1 = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);
  assign head_p1 = ring_pos(head, AW'(1));
  // Count is below DEPTH whenever the tail is written, so its low bits suffice.
  assign tail    = ring_pos(head, count[AW-1:0]);

  // Scan address walks from the front entry toward the back.
  assign raddr      = ring_pos(head, idx);
  assign match      = (rdata == key);
  assign last_issue = ((CW'(idx) + CW'(1)) == count);

  dqs_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (value),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Pointer and count update for the request being taken this cycle.
  always_comb begin
    we         = 1'b0;
    waddr      = head_m1;
    head_next  = head;
    count_next = count;
    res_status = STATUS_OK;
    if (accept) begin
      case (req_type)
        REQ_PUSH_FRONT: begin
          if (full) begin
            res_status = STATUS_FULL;
          end else begin
            we         = 1'b1;
            waddr      = head_m1;
            head_next  = head_m1;
            count_next = count + CW'(1);
          end
        end
        REQ_PUSH_BACK: begin
          if (full) begin
            res_status = STATUS_FULL;
          end else begin
            we         = 1'b1;
            waddr      = tail;
            count_next = count + CW'(1);
          end
        end
        REQ_POP_FRONT: begin
          if (empty) begin
            res_status = STATUS_EMPTY;
          end else begin
            head_next  = head_p1;
            count_next = count - CW'(1);
          end
        end
        REQ_POP_BACK: begin
          if (empty) begin
            res_status = STATUS_EMPTY;
          end else begin
            count_next = count - CW'(1);
          end
        end
        default: begin
          // Search and unused codes leave the ring alone.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
      done  <= 1'b0;
      pend  <= 1'b0;
    end else begin
      head  <= head_next;
      count <= count_next;
      done  <= 1'b0;
      // A read issued in the scan state returns its data in the next cycle.
      pend  <= (state == S_SCAN);
      if (pend && match) begin
        hit <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (req_type == REQ_SEARCH && !empty) begin
              key   <= value;
              idx   <= '0;
              hit   <= 1'b0;
              state <= S_SCAN;
            end else begin
              done      <= 1'b1;
              status    <= res_status;
              found     <= 1'b0;
              occupancy <= OCC_W'(count_next);
            end
          end
        end
        S_SCAN: begin
          // Issue one read per cycle; hold here until the read of the back entry is issued.
          idx <= idx + AW'(1);
          if (last_issue) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          // Last read data is on the RAM output now; fold it in and report.
          done      <= 1'b1;
          status    <= STATUS_OK;
          found     <= hit || match;
          occupancy <= OCC_W'(count);
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/dqs_checker.sv
// Port-level checks for the deque with search, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module dqs_checker
  import dqs_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      start,
  input wire logic                      busy,
  input wire logic [REQ_W-1:0]          req_type,
  input wire logic signed [VALUE_W-1:0] value,
  input wire logic                      done,
  input wire logic [STATUS_W-1:0]       status,
  input wire logic                      found,
  input wire logic [OCC_W-1:0]          occupancy
);

  // Anything but a search gets its result beat in the very next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type != REQ_SEARCH) |=> done)
    else $error("non-search request did not complete in one cycle");

  // found is only set on a successful search beat.
  assert property (@(posedge clk) disable iff (rst)
    (done && found) |-> (status == STATUS_OK))
    else $error("found set with a failing status");

  // A dropped push means the queue sits at full occupancy.
  assert property (@(posedge clk) disable iff (rst)
    (done && status == STATUS_FULL) |-> (occupancy == OCC_W'(DEPTH)))
    else $error("full status with occupancy below depth");

  // A search ends with its result beat when busy drops.
  assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> (done && !$past(done)))
    else $error("busy dropped without a result beat");

  // The request code and value are checked for being known while a request is taken.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> !$isunknown({req_type, value}))
    else $error("request taken with unknown payload");

endmodule

bind deque_with_search dqs_checker #(
  .DEPTH (DEPTH)
) u_dqs_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .req_type  (req_type),
  .value     (value),
  .done      (done),
  .status    (status),
  .found     (found),
  .occupancy (occupancy)
);
`default_nettype wire
